>>> hw/rtl/pfb_pkg.sv
package pfb_pkg;

   localparam int COLUMNS_DEFAULT = 128;
   localparam int PAGES_DEFAULT   = 8;

   localparam logic [2:0] FUNC_POINT = 3'd0;
   localparam logic [2:0] FUNC_START = 3'd1;
   localparam logic [2:0] FUNC_BYTE  = 3'd2;
   localparam logic [2:0] FUNC_CLEAR = 3'd3;
   localparam logic [2:0] FUNC_READ  = 3'd4;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] x;
      logic [7:0] y;
      logic       mode;
      logic [6:0] height;
      logic [7:0] width;
      logic       check;
      logic [7:0] data;
      logic [2:0] page;
      logic [6:0] column;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       status;
   } rsp_type;

endpackage

>>> hw/rtl/page_framebuffer_bitmap_blit.sv
// One-bit page framebuffer of COLUMNS columns by PAGES pages with point and
// bitmap blit drawing. Items arrive on the req_ channel (valid/ready), and
// results leave on the rsp_ channel from an output register, so a result may
// wait there while the next item is accepted.
// Only a blit start and a byte read give a result. A blit start passes
// through the done state into the output register, a byte read through
// the load and done states. The block works on one item at a time. Clear,
// unused codes, points off screen and blit bytes with no blit active are
// handled in the idle state; a point or a blit byte goes through the load,
// shift and write states, skipping the write when its column is off screen
// and nothing is written back: the pixels of the byte are shifted out
// one bit per cycle into a column word that is read from and written back to
// the single-port store.
// The store keeps one word per column with a valid bit per column; a column
// that is not valid reads as zero, so reset and clear take effect at once
// with no sweep of the store.
// Reset clears the valid bits, disables blitting and empties the output
// register. While the receiver stalls, a finished result stays in the output
// register, and an item that has a result of its own waits in the block
// until the register frees, holding off further items.
module page_framebuffer_bitmap_blit
   import pfb_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int PAGES   = PAGES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   localparam int ROWS   = PAGES * 8;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_SHIFT,
      S_WRITE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Column store: bit ROWS-1-y of a column word holds row y.
   logic [ROWS-1:0]   frame_mem [COLUMNS];
   logic [ROWS-1:0]   rd_data_ff;
   logic              rd_valid_ff;
   logic [COLUMNS-1:0] row_valid_ff, row_valid_in;
   logic              mem_re, mem_we;
   logic [7:0]        mem_addr8;
   logic [ADDR_W-1:0] mem_addr;

   // Work registers of the item in progress.
   logic              job_read_ff, job_read_in;
   logic              job_blit_ff, job_blit_in;
   logic [7:0]        col_ff, col_in;
   logic              col_ok_ff, col_ok_in;
   logic [ROWS-1:0]   word_ff, word_in;
   logic [8:0]        row_ff, row_in;
   logic [7:0]        bits_ff, bits_in;
   logic              pol_ff, pol_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [2:0]        page_ff, page_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [7:0]        res_byte_ff, res_byte_in;
   logic              res_status_ff, res_status_in;

   // Blit state.
   logic [7:0]        cursor_ff, cursor_in;
   logic [7:0]        origin_ff, origin_in;
   logic [6:0]        offset_ff, offset_in;
   logic [6:0]        blit_rows_ff, blit_rows_in;
   logic              polarity_ff, polarity_in;
   logic              enabled_ff, enabled_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   logic              accept;
   logic              reject;
   logic              pixel_on;
   logic              last_bit;
   logic [6:0]        offset_next;
   logic [ROW_W-1:0]  bit_idx;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign mem_addr  = mem_addr8[ADDR_W-1:0];

   assign reject = req_item.check &&
                   ((({1'b0, req_item.x} + {1'b0, req_item.width}) > 9'(COLUMNS)) ||
                    (({1'b0, req_item.y} + 9'(req_item.height)) > 9'(ROWS)));

   // A one bit paints the polarity, a zero bit its inverse.
   assign pixel_on    = bits_ff[7] ~^ pol_ff;
   assign bit_idx     = ROW_W'(ROWS - 1) - row_ff[ROW_W-1:0];
   assign offset_next = offset_ff + 7'd1;

   always_comb begin
      state_in      = state_ff;
      row_valid_in  = row_valid_ff;
      job_read_in   = job_read_ff;
      job_blit_in   = job_blit_ff;
      col_in        = col_ff;
      col_ok_in     = col_ok_ff;
      word_in       = word_ff;
      row_in        = row_ff;
      bits_in       = bits_ff;
      pol_in        = pol_ff;
      cnt_in        = cnt_ff;
      page_in       = page_ff;
      rd_ok_in      = rd_ok_ff;
      res_byte_in   = res_byte_ff;
      res_status_in = res_status_ff;
      cursor_in     = cursor_ff;
      origin_in     = origin_ff;
      offset_in     = offset_ff;
      blit_rows_in  = blit_rows_ff;
      polarity_in   = polarity_ff;
      enabled_in    = enabled_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_addr8     = col_ff;
      last_bit      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_item.func)
                  FUNC_POINT: begin
                     if (({1'b0, req_item.x} < 9'(COLUMNS)) &&
                         ({1'b0, req_item.y} < 9'(ROWS))) begin
                        mem_re      = 1'b1;
                        mem_addr8   = req_item.x;
                        col_in      = req_item.x;
                        col_ok_in   = 1'b1;
                        row_in      = {1'b0, req_item.y};
                        bits_in     = {req_item.mode, 7'd0};
                        pol_in      = 1'b1;
                        cnt_in      = 3'd0;
                        job_blit_in = 1'b0;
                        job_read_in = 1'b0;
                        state_in    = S_LOAD;
                     end
                  end
                  FUNC_START: begin
                     if (reject) begin
                        enabled_in = 1'b0;
                     end else begin
                        cursor_in    = req_item.x;
                        origin_in    = req_item.y;
                        offset_in    = 7'd0;
                        blit_rows_in = req_item.height;
                        polarity_in  = req_item.mode;
                        enabled_in   = 1'b1;
                     end
                     res_byte_in   = 8'd0;
                     res_status_in = reject;
                     state_in      = S_DONE;
                  end
                  FUNC_BYTE: begin
                     if (enabled_ff) begin
                        mem_re      = ({1'b0, cursor_ff} < 9'(COLUMNS));
                        mem_addr8   = cursor_ff;
                        col_in      = cursor_ff;
                        col_ok_in   = ({1'b0, cursor_ff} < 9'(COLUMNS));
                        row_in      = {1'b0, origin_ff} + 9'(offset_ff);
                        bits_in     = req_item.data;
                        pol_in      = polarity_ff;
                        cnt_in      = 3'd7;
                        job_blit_in = 1'b1;
                        job_read_in = 1'b0;
                        state_in    = S_LOAD;
                     end
                  end
                  FUNC_CLEAR: begin
                     row_valid_in = '0;
                  end
                  FUNC_READ: begin
                     rd_ok_in    = ({2'b0, req_item.column} < 9'(COLUMNS)) &&
                                   ({2'b0, req_item.page} < 5'(PAGES));
                     mem_re      = ({2'b0, req_item.column} < 9'(COLUMNS));
                     mem_addr8   = {1'b0, req_item.column};
                     page_in     = req_item.page;
                     job_read_in = 1'b1;
                     state_in    = S_LOAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOAD: begin
            if (job_read_ff) begin
               res_byte_in   = (rd_ok_ff && rd_valid_ff) ?
                               8'(rd_data_ff >> {page_ff, 3'b000}) : 8'd0;
               res_status_in = 1'b0;
               state_in      = S_DONE;
            end else begin
               word_in  = rd_valid_ff ? rd_data_ff : '0;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (row_ff < 9'(ROWS)) begin
               word_in[bit_idx] = pixel_on;
            end
            bits_in  = {bits_ff[6:0], 1'b0};
            row_in   = row_ff + 9'd1;
            cnt_in   = cnt_ff - 3'd1;
            last_bit = (cnt_ff == 3'd0);
            if (job_blit_ff) begin
               // At the glyph height the cursor moves on and the rest of the
               // byte is dropped.
               if (offset_next == blit_rows_ff) begin
                  offset_in = 7'd0;
                  cursor_in = cursor_ff + 8'd1;
                  last_bit  = 1'b1;
               end else begin
                  offset_in = offset_next;
               end
            end
            if (last_bit) begin
               state_in = col_ok_ff ? S_WRITE : S_IDLE;
            end
         end
         S_WRITE: begin
            mem_we                 = 1'b1;
            row_valid_in[mem_addr] = 1'b1;
            state_in               = S_IDLE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_item_in.byte_out = res_byte_ff;
               rsp_item_in.status   = res_status_ff;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= word_ff;
      end
      if (mem_re) begin
         rd_data_ff  <= frame_mem[mem_addr];
         rd_valid_ff <= row_valid_ff[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         cursor_ff    <= 8'd0;
         origin_ff    <= 8'd0;
         offset_ff    <= 7'd0;
         blit_rows_ff <= 7'd1;
         polarity_ff  <= 1'b1;
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_valid_ff  <= row_valid_in;
         cursor_ff     <= cursor_in;
         origin_ff     <= origin_in;
         offset_ff     <= offset_in;
         blit_rows_ff  <= blit_rows_in;
         polarity_ff   <= polarity_in;
         enabled_ff    <= enabled_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_item_ff   <= rsp_item_in;
         job_read_ff   <= job_read_in;
         job_blit_ff   <= job_blit_in;
         col_ff        <= col_in;
         col_ok_ff     <= col_ok_in;
         word_ff       <= word_in;
         row_ff        <= row_in;
         bits_ff       <= bits_in;
         pol_ff        <= pol_in;
         cnt_ff        <= cnt_in;
         page_ff       <= page_in;
         rd_ok_ff      <= rd_ok_in;
         res_byte_ff   <= res_byte_in;
         res_status_ff <= res_status_in;
      end
   end

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.func == FUNC_CLEAR |=> row_valid_ff == '0)
      else $error("clear left a column marked valid");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ({1'b0, col_ff} < 9'(COLUMNS)) && col_ok_ff)
      else $error("store write outside the column range");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside the done state");

   a_point_one_pixel: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT && !job_blit_ff |=> state_ff != S_SHIFT)
      else $error("point painted more than one pixel");

endmodule
